>>> hw/rtl/rsls_pkg.sv
// Shared types, codes and reset constants of the random looping shift sequencer.
package rsls_pkg;

    // Default sizes handed to the top level.
    localparam int DEF_TRACKS   = 8;
    localparam int DEF_REG_BITS = 16;

    // Configuration port geometry.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Trigger length counter width.
    localparam int PULSE_W = 10;

    // Field widths fixed by the item format.
    localparam int TRACK_W  = 3;
    localparam int LOOP_W   = 5;
    localparam int KNOB_W   = 11;
    localparam int CV_W     = 15;
    localparam int DIGIT_W  = 4;
    localparam int OUTREG_W = 16;

    // Control arithmetic constants.
    localparam int CTRL_W    = 17;
    localparam int MAG_W     = 14;
    localparam int KNOB_SCALE = 10;
    localparam int CTRL_LIMIT = 10000;
    localparam int DIGIT_STEP = 1000;

    // Output modes.
    typedef enum logic [1:0] {
        MODE_TRIGGER     = 2'd0,
        MODE_GATE        = 2'd1,
        MODE_CLOCK_PULSE = 2'd2,
        MODE_HOLD        = 2'd3
    } mode_t;

    // Item commands.
    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_CLEAR = 1'b1
    } cmd_t;

    // Register byte addresses.
    typedef enum logic [PADDR_W-1:0] {
        ADDR_OUTPUT_MODE = 4'h0,
        ADDR_HOLD        = 4'h4,
        ADDR_PULSE_TICKS = 4'h8
    } reg_addr_t;

    // Register reset values.
    localparam mode_t               RST_OUTPUT_MODE = MODE_TRIGGER;
    localparam logic                RST_HOLD        = 1'b1;
    localparam logic [PULSE_W-1:0]  RST_PULSE_TICKS = 10'd48;

    // Configuration seen by the step logic.
    typedef struct packed {
        mode_t               output_mode;
        logic                hold_after_reset;
        logic [PULSE_W-1:0]  pulse_ticks;
    } cfg_t;

    // Per-track edge and output state kept next to the shift register.
    typedef struct packed {
        logic                last_clock;
        logic                last_reset;
        logic                skip_advance;
        logic                pulse_active;
        logic                gate_level;
        logic                out_level;
        logic [PULSE_W-1:0]  pulse_left;
    } track_flags_t;

endpackage

>>> hw/rtl/rsls_cfg_regs.sv
// Configuration registers of the sequencer behind an APB-style port.
module rsls_cfg_regs
    import rsls_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output cfg_t                cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    // The port is always ready, so the access phase completes the write.
    assign wr_en = psel & penable & pwrite;

    // Register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.output_mode      <= RST_OUTPUT_MODE;
            cfg_reg.hold_after_reset <= RST_HOLD;
            cfg_reg.pulse_ticks      <= RST_PULSE_TICKS;
        end
        else if (wr_en)
        begin
            unique case (paddr)
                ADDR_OUTPUT_MODE: cfg_reg.output_mode      <= mode_t'(pwdata[1:0]);
                ADDR_HOLD:        cfg_reg.hold_after_reset <= pwdata[0];
                ADDR_PULSE_TICKS: cfg_reg.pulse_ticks      <= pwdata[PULSE_W-1:0];
                default:          cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // Read mux.
    always_comb
    begin
        unique case (paddr)
            ADDR_OUTPUT_MODE: prdata = PDATA_W'(cfg_reg.output_mode);
            ADDR_HOLD:        prdata = PDATA_W'(cfg_reg.hold_after_reset);
            ADDR_PULSE_TICKS: prdata = PDATA_W'(cfg_reg.pulse_ticks);
            default:          prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/rsls_step.sv
// Next-state logic of one track: reset rotation, clock advance and output shaping.
module rsls_step
    import rsls_pkg::*;
#(
    parameter int REG_BITS = DEF_REG_BITS
)(
    input  cfg_t                              cfg,
    input  logic                              clock_high,
    input  logic                              reset_high,
    input  logic                              raw_clock_high,
    input  logic [LOOP_W-1:0]                 loop_length,
    input  logic signed [KNOB_W-1:0]          control_knob,
    input  logic signed [CV_W-1:0]            control_cv,
    input  logic [DIGIT_W-1:0]                random_digit,
    input  logic                              random_bit,
    input  track_flags_t                      cur_flags,
    input  logic [$clog2(REG_BITS)-1:0]       cur_start,
    input  logic [REG_BITS-1:0]               cur_shift,
    output track_flags_t                      nxt_flags,
    output logic [$clog2(REG_BITS)-1:0]       nxt_start,
    output logic [REG_BITS-1:0]               nxt_shift
);

    localparam int SW = $clog2(REG_BITS);
    localparam int LW = $clog2(REG_BITS + 1);
    localparam int PK = $clog2(REG_BITS);

    logic [LW-1:0]              len;
    logic [REG_BITS-1:0]        mask_len;
    logic [REG_BITS-1:0]        mask_start;
    logic [REG_BITS-1:0]        low_bits;
    logic [REG_BITS-1:0]        rot_bits;
    logic [REG_BITS-1:0]        period_bits;
    logic [REG_BITS-1:0]        rotated;
    logic                       start_in_loop;
    logic                       rst_edge;
    logic                       clk_edge;
    logic                       advance;
    logic [REG_BITS-1:0]        shift_a;
    logic [SW-1:0]              start_a;
    logic                       skip_a;
    logic [LW:0]                start_inc;
    logic signed [CTRL_W-1:0]   knob_x;
    logic signed [CTRL_W-1:0]   cv_x;
    logic signed [CTRL_W-1:0]   ctrl;
    logic                       ctrl_neg;
    logic [CTRL_W-1:0]          ctrl_abs;
    logic [MAG_W-1:0]           mag;
    logic [MAG_W-1:0]           digit_level;
    logic                       draw_new;
    logic                       recycled;
    logic                       new_bit;
    track_flags_t               f;

    // Loop length clamped to one through the register width.
    always_comb
    begin
        if (loop_length == '0)
        begin
            len = LW'(1);
        end
        else if (32'(loop_length) > REG_BITS)
        begin
            len = LW'(REG_BITS);
        end
        else
        begin
            len = LW'(loop_length);
        end
    end

    // Rotate the register so the start step comes first, then repeat the loop.
    always_comb
    begin
        mask_len      = REG_BITS'(({{REG_BITS{1'b0}}, 1'b1} << len) - 1'b1);
        mask_start    = REG_BITS'(({{REG_BITS{1'b0}}, 1'b1} << cur_start) - 1'b1);
        start_in_loop = 32'(cur_start) < 32'(len);
        low_bits      = cur_shift & mask_len;
        rot_bits      = ((low_bits >> cur_start) | (low_bits << (len - LW'(cur_start))))
                        & mask_len;
        period_bits   = start_in_loop ? rot_bits : low_bits;
        // Doubling the covered span each pass fills the whole register.
        for (int k = 0; k < PK; k++)
        begin
            period_bits = period_bits | (period_bits << (32'(len) << k));
        end
        if (start_in_loop)
        begin
            rotated = period_bits;
        end
        else
        begin
            rotated = (cur_shift & mask_start) | ((period_bits << cur_start) & ~mask_start);
        end
    end

    // Edge detection and the reset step.
    assign rst_edge = reset_high & ~cur_flags.last_reset;
    assign clk_edge = clock_high & ~cur_flags.last_clock;
    assign shift_a  = rst_edge ? rotated : cur_shift;
    assign start_a  = rst_edge ? '0 : cur_start;
    assign skip_a   = (rst_edge & cfg.hold_after_reset) | cur_flags.skip_advance;
    assign advance  = clk_edge & ~skip_a;

    // Control value in ten-thousandths, saturated, and the random compare.
    always_comb
    begin
        knob_x   = CTRL_W'(control_knob);
        cv_x     = CTRL_W'(control_cv);
        ctrl     = knob_x * CTRL_W'(KNOB_SCALE) + cv_x;
        ctrl_neg = ctrl < 0;
        ctrl_abs = ctrl_neg ? CTRL_W'(-ctrl) : CTRL_W'(ctrl);
        if (ctrl_abs > CTRL_W'(CTRL_LIMIT))
        begin
            mag = MAG_W'(CTRL_LIMIT);
        end
        else
        begin
            mag = ctrl_abs[MAG_W-1:0];
        end
        // digit > floor(mag / 1000) is the same as mag < digit * 1000.
        digit_level = MAG_W'(random_digit) * MAG_W'(DIGIT_STEP);
        draw_new    = mag < digit_level;
        recycled    = shift_a[SW'(len - LW'(1))] ^ ctrl_neg;
        new_bit     = draw_new ? random_bit : recycled;
    end

    // Start step advance, wrapping at the loop length.
    assign start_inc = (LW+1)'(start_a) + (LW+1)'(1);

    always_comb
    begin
        nxt_start = start_a;
        nxt_shift = shift_a;
        if (advance)
        begin
            nxt_start = (start_inc >= (LW+1)'(len)) ? '0 : SW'(start_inc);
            nxt_shift = {shift_a[REG_BITS-2:0], new_bit};
        end
    end

    // Pulse, gate and output level.
    always_comb
    begin
        f              = cur_flags;
        f.skip_advance = skip_a;
        if (clk_edge & skip_a)
        begin
            f.skip_advance = 1'b0;
        end
        if (advance)
        begin
            if (new_bit)
            begin
                f.pulse_active = 1'b1;
                f.pulse_left   = cfg.pulse_ticks;
                if (cfg.output_mode == MODE_GATE)
                begin
                    f.gate_level = 1'b1;
                end
            end
            else if (cfg.output_mode == MODE_GATE)
            begin
                f.gate_level = 1'b0;
                f.out_level  = 1'b0;
            end
        end
        if (f.pulse_active)
        begin
            unique case (cfg.output_mode)
                MODE_TRIGGER:
                begin
                    if (f.pulse_left == '0)
                    begin
                        f.pulse_active = 1'b0;
                        f.out_level    = 1'b0;
                    end
                    else
                    begin
                        f.pulse_left = f.pulse_left - 1'b1;
                        f.out_level  = 1'b1;
                    end
                end
                MODE_CLOCK_PULSE:
                begin
                    f.out_level = raw_clock_high;
                    if (!raw_clock_high)
                    begin
                        f.pulse_active = 1'b0;
                    end
                end
                MODE_GATE:
                begin
                    f.out_level = f.gate_level;
                end
                MODE_HOLD:
                begin
                    f.out_level = f.out_level;
                end
            endcase
        end
        f.last_reset = reset_high;
        f.last_clock = clock_high;
        nxt_flags    = f;
    end

endmodule

>>> hw/rtl/random_looping_shift_sequencer.sv
// Top level of the random looping shift sequencer: track memory, pipeline and handshakes.
//
// Usage: each item beat on the item channel is one sample tick for one track, or a
// clear command that zeroes every track's shift register. Every item gives exactly
// one result beat with the track index, the output level and the track's register.
// Per-track state lives in one synchronous memory indexed by track. An accepted
// item reads its track's entry at the accepting edge; the compute stage then forms the
// new state and, when it hands its beat on, writes a tick's state back and loads the
// result register. A write forwarded from the previous item covers two items for the
// same track in a row. One item per cycle is sustained as long as result_ready is
// high; the memory's single read and write port set that rate.
// After reset the memory contents are ignored: per-track valid bits make every
// track read as all-zero state, and a clear command drops the shift-register
// valid bits the same way, so neither has to clear the memory itself.
// When the receiver stalls, the result register holds its beat and one more item
// is taken into the compute stage before item_ready drops.
// The user writes registers over the APB-style port only while idle; the block does not enforce it.
module random_looping_shift_sequencer
    import rsls_pkg::*;
#(
    parameter int TRACKS   = DEF_TRACKS,
    parameter int REG_BITS = DEF_REG_BITS
)(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [PADDR_W-1:0]          paddr,
    input  logic [PDATA_W-1:0]          pwdata,
    output logic [PDATA_W-1:0]          prdata,
    output logic                        pready,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  logic                        command,
    input  logic [TRACK_W-1:0]          track,
    input  logic                        clock_high,
    input  logic                        reset_high,
    input  logic                        raw_clock_high,
    input  logic [LOOP_W-1:0]           loop_length,
    input  logic signed [KNOB_W-1:0]    control_knob,
    input  logic signed [CV_W-1:0]      control_cv,
    input  logic [DIGIT_W-1:0]          random_digit,
    input  logic                        random_bit,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic [TRACK_W-1:0]          result_track,
    output logic                        out_high,
    output logic [OUTREG_W-1:0]         register_bits
);

    localparam int TW      = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int SW      = $clog2(REG_BITS);
    localparam int FLAGS_W = $bits(track_flags_t);
    localparam int ENTRY_W = FLAGS_W + SW + REG_BITS;

    cfg_t                       cfg;

    // Track memory and its registered read port.
    logic [ENTRY_W-1:0]         mem [TRACKS];
    logic [ENTRY_W-1:0]         rd_data_reg;

    // Compute stage.
    logic                       s1_valid_reg;
    cmd_t                       s1_cmd_reg;
    logic [TRACK_W-1:0]         s1_track_reg;
    logic                       s1_clock_reg;
    logic                       s1_reset_reg;
    logic                       s1_raw_reg;
    logic [LOOP_W-1:0]          s1_len_reg;
    logic signed [KNOB_W-1:0]   s1_knob_reg;
    logic signed [CV_W-1:0]     s1_cv_reg;
    logic [DIGIT_W-1:0]         s1_digit_reg;
    logic                       s1_rbit_reg;
    logic                       fwd_hit_reg;
    logic [ENTRY_W-1:0]         fwd_data_reg;

    // Per-track valid bits: whole entry and shift register.
    logic [TRACKS-1:0]          rec_valid_reg;
    logic [TRACKS-1:0]          sh_valid_reg;

    // Result register.
    logic                       out_valid_reg;
    logic [TRACK_W-1:0]         out_track_reg;
    logic                       out_high_reg;
    logic [OUTREG_W-1:0]        out_bits_reg;

    logic                       item_accept;
    logic                       s1_move;
    logic [TW-1:0]              item_addr;
    logic [TW-1:0]              s1_addr;
    logic                       s1_track_ok;
    logic                       wr_en;
    logic [ENTRY_W-1:0]         wr_data;
    logic [ENTRY_W-1:0]         entry;
    track_flags_t               cur_flags;
    logic [SW-1:0]              cur_start;
    logic [REG_BITS-1:0]        cur_shift;
    track_flags_t               nxt_flags;
    logic [SW-1:0]              nxt_start;
    logic [REG_BITS-1:0]        nxt_shift;

    rsls_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // Handshake and stage advance.
    assign s1_move     = s1_valid_reg & (~out_valid_reg | result_ready);
    assign item_ready  = ~s1_valid_reg | s1_move;
    assign item_accept = item_valid & item_ready;

    assign item_addr   = TW'(track);
    assign s1_addr     = TW'(s1_track_reg);
    assign s1_track_ok = 32'(s1_track_reg) < 32'(TRACKS);

    // Write back happens when the compute stage hands on a tick for a track in range.
    assign wr_en   = s1_move & (s1_cmd_reg == CMD_TICK) & s1_track_ok;
    assign wr_data = {nxt_flags, nxt_start, nxt_shift};

    // Memory: read at accept, write from the compute stage; read returns old data.
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            rd_data_reg <= mem[item_addr];
        end
        if (wr_en)
        begin
            mem[s1_addr] <= wr_data;
        end
    end

    // Forward a write that lands at the same edge as the read of the same track.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (item_accept)
        begin
            fwd_hit_reg <= wr_en & (s1_addr == item_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    // Valid bits: reset empties every track, a clear empties every shift register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_valid_reg <= '0;
            sh_valid_reg  <= '0;
        end
        else if (s1_move & (s1_cmd_reg == CMD_CLEAR))
        begin
            sh_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            rec_valid_reg[s1_addr] <= 1'b1;
            sh_valid_reg[s1_addr]  <= 1'b1;
        end
    end

    // Compute stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Compute stage payload.
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_cmd_reg   <= cmd_t'(command);
            s1_track_reg <= track;
            s1_clock_reg <= clock_high;
            s1_reset_reg <= reset_high;
            s1_raw_reg   <= raw_clock_high;
            s1_len_reg   <= loop_length;
            s1_knob_reg  <= control_knob;
            s1_cv_reg    <= control_cv;
            s1_digit_reg <= random_digit;
            s1_rbit_reg  <= random_bit;
        end
    end

    // Current entry: forwarded or read, with never-written parts reading as zero.
    always_comb
    begin
        entry = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        if (s1_track_ok && rec_valid_reg[s1_addr])
        begin
            cur_flags = track_flags_t'(entry[ENTRY_W-1 -: FLAGS_W]);
            cur_start = entry[REG_BITS +: SW];
        end
        else
        begin
            cur_flags = '0;
            cur_start = '0;
        end
        if (s1_track_ok && sh_valid_reg[s1_addr])
        begin
            cur_shift = entry[REG_BITS-1:0];
        end
        else
        begin
            cur_shift = '0;
        end
    end

    rsls_step #(
        .REG_BITS (REG_BITS)
    ) u_step (
        .cfg            (cfg),
        .clock_high     (s1_clock_reg),
        .reset_high     (s1_reset_reg),
        .raw_clock_high (s1_raw_reg),
        .loop_length    (s1_len_reg),
        .control_knob   (s1_knob_reg),
        .control_cv     (s1_cv_reg),
        .random_digit   (s1_digit_reg),
        .random_bit     (s1_rbit_reg),
        .cur_flags      (cur_flags),
        .cur_start      (cur_start),
        .cur_shift      (cur_shift),
        .nxt_flags      (nxt_flags),
        .nxt_start      (nxt_start),
        .nxt_shift      (nxt_shift)
    );

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload: a clear gives track level, empty register; a bad track gives zeros.
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_track_reg <= s1_track_reg;
            if (!s1_track_ok)
            begin
                out_high_reg <= 1'b0;
                out_bits_reg <= '0;
            end
            else if (s1_cmd_reg == CMD_CLEAR)
            begin
                out_high_reg <= cur_flags.out_level;
                out_bits_reg <= '0;
            end
            else
            begin
                out_high_reg <= nxt_flags.out_level;
                out_bits_reg <= OUTREG_W'(nxt_shift);
            end
        end
    end

    assign result_valid  = out_valid_reg;
    assign result_track  = out_track_reg;
    assign out_high      = out_high_reg;
    assign register_bits = out_bits_reg;

endmodule
